### sv/wmsd_pkg.sv
// ----------------------------------------------------------------------------
// wmsd_pkg: shared types and constants
// register indices, payload structs, sequencer states and control bundles
// ----------------------------------------------------------------------------
package wmsd_pkg;

   localparam int COORD_BITS     = 12;
   localparam int SIZE_BITS      = 13;
   localparam int PIX_BITS       = 8;
   localparam int SQ_BITS        = 2 * PIX_BITS;
   localparam int MEAN_BITS      = 24;
   localparam int COUNT_OUT_BITS = 13;
   localparam int FRAC_BITS      = 8;
   localparam int LIM_BITS       = SIZE_BITS + 1;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = SIZE_BITS;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type REG_WINDOW_LEFT = 3'd0;
   localparam csr_index_type REG_WINDOW_TOP  = 3'd1;
   localparam csr_index_type REG_MATCH_LEFT  = 3'd2;
   localparam csr_index_type REG_MATCH_TOP   = 3'd3;
   localparam csr_index_type REG_WIDTH_A     = 3'd4;
   localparam csr_index_type REG_HEIGHT_A    = 3'd5;
   localparam csr_index_type REG_WIDTH_B     = 3'd6;
   localparam csr_index_type REG_HEIGHT_B    = 3'd7;

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = 13'h1000;

   typedef struct packed {
      logic [COORD_BITS-1:0] col;
      logic [COORD_BITS-1:0] row;
      logic [PIX_BITS-1:0]   pixel_a;
      logic [PIX_BITS-1:0]   pixel_b;
      logic                  last;
   } req_type;

   typedef struct packed {
      logic [MEAN_BITS-1:0]      mean_sq;
      logic [COUNT_OUT_BITS-1:0] used_count;
      logic                      empty_res;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] window_left;
      logic [COORD_BITS-1:0] window_top;
      logic [COORD_BITS-1:0] match_left;
      logic [COORD_BITS-1:0] match_top;
      logic [SIZE_BITS-1:0]  width_a;
      logic [SIZE_BITS-1:0]  height_a;
      logic [SIZE_BITS-1:0]  width_b;
      logic [SIZE_BITS-1:0]  height_b;
   } cfg_type;

   typedef struct packed {
      logic take;
      logic clear;
   } acc_ctrl_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic done;
   } div_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_FINISH
   } state_type;

endpackage

### sv/wmsd_acc.sv
// ----------------------------------------------------------------------------
// wmsd_acc: bounds test and squared difference accumulator
// skips pairs on or past the last column or row or once the count is at the cap, sums squares, counts pairs
// ----------------------------------------------------------------------------
module wmsd_acc import wmsd_pkg::*; #(
   parameter int MAX_WINDOW_PIXELS = 4096,
   parameter int CNTW = 13,
   parameter int SUMW = 29
) (
   input  logic             clock,
   input  logic             reset,
   input  acc_ctrl_type     ctrl,
   input  req_type          req,
   input  cfg_type          cfg,
   output logic [SUMW-1:0]  sq_sum,
   output logic [CNTW-1:0]  pair_count
);

   logic [SUMW-1:0]     sum_ff, sum_in;
   logic [CNTW-1:0]     cnt_ff, cnt_in;
   logic [LIM_BITS-1:0] a_col, a_row, b_col, b_row;
   logic [LIM_BITS-1:0] b_col_lim, b_row_lim;
   logic                skip, room, use_pair;
   logic [PIX_BITS-1:0] diff;
   logic [SQ_BITS-1:0]  sq;

   // x >= w-1 rewritten as x+1 >= w; b side moves window_left to the right
   always_comb begin
      a_col     = LIM_BITS'(req.col) + LIM_BITS'(1);
      a_row     = LIM_BITS'(req.row) + LIM_BITS'(1);
      b_col     = LIM_BITS'(cfg.match_left) + LIM_BITS'(req.col) + LIM_BITS'(1);
      b_row     = LIM_BITS'(cfg.match_top) + LIM_BITS'(req.row) + LIM_BITS'(1);
      b_col_lim = LIM_BITS'(cfg.width_b) + LIM_BITS'(cfg.window_left);
      b_row_lim = LIM_BITS'(cfg.height_b) + LIM_BITS'(cfg.window_top);
      skip      = (a_col >= LIM_BITS'(cfg.width_a)) || (a_row >= LIM_BITS'(cfg.height_a)) ||
                  (b_col >= b_col_lim) || (b_row >= b_row_lim);
      room      = cnt_ff < CNTW'(MAX_WINDOW_PIXELS);
      use_pair  = ctrl.take && !skip && room;
      diff      = (req.pixel_a >= req.pixel_b) ? (req.pixel_a - req.pixel_b)
                                               : (req.pixel_b - req.pixel_a);
      sq        = SQ_BITS'(diff) * SQ_BITS'(diff);
   end

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (ctrl.clear) begin
         sum_in = '0;
         cnt_in = '0;
      end else if (use_pair) begin
         sum_in = sum_ff + SUMW'(sq);
         cnt_in = cnt_ff + CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
   end

   assign sq_sum     = sum_ff;
   assign pair_count = cnt_ff;

endmodule

### sv/wmsd_div.sv
// ----------------------------------------------------------------------------
// wmsd_div: iterative restoring divider
// one quotient bit per cycle through a single shared subtractor
// ----------------------------------------------------------------------------
module wmsd_div import wmsd_pkg::*; #(
   parameter int CNTW = 13,
   parameter int SUMW = 29
) (
   input  logic                 clock,
   input  logic                 reset,
   input  div_ctrl_type         ctrl,
   input  logic [SUMW-1:0]      dividend,
   input  logic [CNTW-1:0]      divisor,
   output div_stat_type         stat,
   output logic [MEAN_BITS-1:0] quotient
);

   localparam int STEPW = $clog2(MEAN_BITS);
   localparam int LOWW  = MEAN_BITS - FRAC_BITS;

   logic [CNTW-1:0]      rem_ff, rem_in;
   logic [MEAN_BITS-1:0] quo_ff, quo_in;
   logic [CNTW-1:0]      dsr_ff, dsr_in;
   logic [STEPW-1:0]     step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNTW+1:0]      trial;
   logic                 qbit;

   // quotient stays below 2^24, so the upper dividend bits start below the divisor
   always_comb begin
      trial = {1'b0, rem_ff, quo_ff[MEAN_BITS-1]} - {2'b00, dsr_ff};
      qbit  = !trial[CNTW+1];
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         rem_in  = dividend[SUMW-1:LOWW];
         quo_in  = {dividend[LOWW-1:0], FRAC_BITS'(0)};
         dsr_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = qbit ? trial[CNTW-1:0] : {rem_ff[CNTW-2:0], quo_ff[MEAN_BITS-1]};
         quo_in  = {quo_ff[MEAN_BITS-2:0], qbit};
         step_in = step_ff + STEPW'(1);
         if (step_ff == STEPW'(MEAN_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

### sv/window_mean_squared_difference.sv
// ----------------------------------------------------------------------------
// window_mean_squared_difference: windowed mean squared pixel difference
// sums squared pixel differences over a window and divides by the pair count
// ----------------------------------------------------------------------------
//
//   channel  ports                          direction  payload
//   req      req_valid req_stall req_data   in         col row pixel_a pixel_b last
//   rsp      rsp_valid rsp_stall rsp_data   out        mean_sq used_count empty_res
//   csr      csr_we csr_index csr_wdata     in         eight window and image regs
//
// an item without last is taken back to back while the sequencer is idle
// an item with last goes through accumulate, load, 24 divider steps, a wait to
//   see the registered divider done, finish; its result is then offered from the
//   output register; the 24 steps share one subtractor, one quotient bit each
// the result sits in an output register; the next window may start while it waits
// finish waits while the output register still holds an untaken result
// reset is synchronous; it clears sums, sequencer, origins; sizes go to 4096
//
module window_mean_squared_difference import wmsd_pkg::*; #(
   parameter int MAX_WINDOW_PIXELS = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // pair counter holds the cap itself; the sum bounds 255^2 per pair
   localparam int CNTW = $clog2(MAX_WINDOW_PIXELS + 1);
   localparam int SUMW = CNTW + SQ_BITS;

   cfg_type         cfg_ff, cfg_in;
   state_type       state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   acc_ctrl_type    acc_ctrl;
   div_ctrl_type    div_ctrl;
   div_stat_type    div_stat;
   logic [SUMW-1:0] sq_sum;
   logic [CNTW-1:0] pair_count;
   logic [MEAN_BITS-1:0] quotient;
   logic [CNTW+COUNT_OUT_BITS-1:0] count_ext;
   logic            req_take;
   logic            out_free;

   // ---------------------------------------------------------------- registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_WINDOW_LEFT: cfg_in.window_left = csr_wdata[COORD_BITS-1:0];
            REG_WINDOW_TOP:  cfg_in.window_top  = csr_wdata[COORD_BITS-1:0];
            REG_MATCH_LEFT:  cfg_in.match_left  = csr_wdata[COORD_BITS-1:0];
            REG_MATCH_TOP:   cfg_in.match_top   = csr_wdata[COORD_BITS-1:0];
            REG_WIDTH_A:     cfg_in.width_a     = csr_wdata;
            REG_HEIGHT_A:    cfg_in.height_a    = csr_wdata;
            REG_WIDTH_B:     cfg_in.width_b     = csr_wdata;
            REG_HEIGHT_B:    cfg_in.height_b    = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------- sequencer
   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_take && req_data.last) state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_DIV;
         ST_DIV:    if (div_stat.done) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall      = 1'b1;
      acc_ctrl.take  = 1'b0;
      acc_ctrl.clear = 1'b0;
      div_ctrl.start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall     = 1'b0;
            acc_ctrl.take = req_take;
         end
         // the sum now includes the last item, so the divider loads here
         ST_LOAD:   div_ctrl.start = 1'b1;
         ST_DIV:    ;
         // result moves to the output register, window state starts over
         ST_FINISH: acc_ctrl.clear = out_free;
         default:   ;
      endcase
   end

   // ---------------------------------------------------------------- output
   assign count_ext = {COUNT_OUT_BITS'(0), pair_count};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == ST_FINISH && out_free) begin
         rsp_valid_in = 1'b1;
         if (pair_count == '0) begin
            // empty window: no division result, flag it instead
            rsp_data_in.mean_sq    = '0;
            rsp_data_in.used_count = '0;
            rsp_data_in.empty_res  = 1'b1;
         end else begin
            rsp_data_in.mean_sq    = quotient;
            rsp_data_in.used_count = count_ext[COUNT_OUT_BITS-1:0];
            rsp_data_in.empty_res  = 1'b0;
         end
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_left <= '0;
         cfg_ff.window_top  <= '0;
         cfg_ff.match_left  <= '0;
         cfg_ff.match_top   <= '0;
         cfg_ff.width_a     <= SIZE_RESET;
         cfg_ff.height_a    <= SIZE_RESET;
         cfg_ff.width_b     <= SIZE_RESET;
         cfg_ff.height_b    <= SIZE_RESET;
         state_ff           <= ST_IDLE;
         rsp_valid_ff       <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- units
   wmsd_acc #(
      .MAX_WINDOW_PIXELS(MAX_WINDOW_PIXELS),
      .CNTW(CNTW),
      .SUMW(SUMW)
   ) u_acc (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (acc_ctrl),
      .req        (req_data),
      .cfg        (cfg_ff),
      .sq_sum     (sq_sum),
      .pair_count (pair_count)
   );

   // quotient = floor(sq_sum * 256 / pair_count)
   wmsd_div #(
      .CNTW(CNTW),
      .SUMW(SUMW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (sq_sum),
      .divisor  (pair_count),
      .stat     (div_stat),
      .quotient (quotient)
   );

endmodule

### sv/wmsd_check.sv
// ----------------------------------------------------------------------------
// wmsd_check: port level checks
// watches the handshakes and the result fields of the top level
// ----------------------------------------------------------------------------
module wmsd_check import wmsd_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input req_type                   req_data,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input rsp_type                   rsp_data
);

   // a stalled result item stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   // a stalled result item keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

   // an empty window reports zero mean and zero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.empty_res |->
         rsp_data.mean_sq == '0 && rsp_data.used_count == '0)
      else $error("empty result with nonzero fields");

   // the closing item of a window makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.last |=> req_stall)
      else $error("input not stalled after closing item");

   // only the closing item of a window produces a result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_data.last |=> !$rose(rsp_valid))
      else $error("result item after an item without last");

endmodule

bind window_mean_squared_difference wmsd_check u_wmsd_check (.*);

### bench/wmsd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wmsd_checker: result checker for the windowed mean squared difference
// follows register writes and accepted pixel items, computes each window's
// mean, count and empty flag, and compares them with the accepted results
// ----------------------------------------------------------------------------
module wmsd_checker import wmsd_pkg::*; #(
   parameter int MAX_WINDOW_PIXELS = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  req_type                   req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  rsp_type                   rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        pending,
   output int                        failures
);

   cfg_type              regs_copy;
   logic [27:0]          sq_total;
   logic [SIZE_BITS-1:0] pairs_taken;
   rsp_type              window_means[$];
   int                   fail_count = 0;

   // signed bounds test on both images
   function automatic bit pair_outside(input cfg_type c, input req_type r);
      int bcol, brow;
      bcol = int'(c.match_left) + int'(r.col) - int'(c.window_left);
      brow = int'(c.match_top) + int'(r.row) - int'(c.window_top);
      return int'(r.col) >= int'(c.width_a) - 1 || int'(r.row) >= int'(c.height_a) - 1 ||
             bcol >= int'(c.width_b) - 1 || brow >= int'(c.height_b) - 1;
   endfunction

   always @(posedge clock) begin : track
      rsp_type           want;
      int                diff;
      longint unsigned   scaled;
      if (reset) begin
         regs_copy   = '{window_left: '0, window_top: '0, match_left: '0, match_top: '0,
                         width_a: SIZE_RESET, height_a: SIZE_RESET,
                         width_b: SIZE_RESET, height_b: SIZE_RESET};
         sq_total    = '0;
         pairs_taken = '0;
         window_means.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (window_means.size() == 0) begin
               $error("unexpected result: mean_sq %0d used_count %0d empty_res %0d",
                      rsp_data.mean_sq, rsp_data.used_count, rsp_data.empty_res);
               fail_count++;
            end else begin
               want = window_means.pop_front();
               if (rsp_data.mean_sq !== want.mean_sq) begin
                  $error("mean_sq mismatch: expected %0d, actual %0d",
                         want.mean_sq, rsp_data.mean_sq);
                  fail_count++;
               end
               if (rsp_data.used_count !== want.used_count) begin
                  $error("used_count mismatch: expected %0d, actual %0d",
                         want.used_count, rsp_data.used_count);
                  fail_count++;
               end
               if (rsp_data.empty_res !== want.empty_res) begin
                  $error("empty_res mismatch: expected %0d, actual %0d",
                         want.empty_res, rsp_data.empty_res);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (!pair_outside(regs_copy, req_data) && pairs_taken < MAX_WINDOW_PIXELS) begin
               diff = int'(req_data.pixel_a) - int'(req_data.pixel_b);
               sq_total    = sq_total + 28'(diff * diff);
               pairs_taken = pairs_taken + SIZE_BITS'(1);
            end
            if (req_data.last) begin
               if (pairs_taken == 0) begin
                  want = '{mean_sq: '0, used_count: '0, empty_res: 1'b1};
               end else begin
                  scaled = {36'd0, sq_total} << FRAC_BITS;
                  scaled = scaled / pairs_taken;
                  want = '{mean_sq: scaled[MEAN_BITS-1:0], used_count: pairs_taken,
                           empty_res: 1'b0};
               end
               window_means.push_back(want);
               sq_total    = '0;
               pairs_taken = '0;
            end
         end
         if (csr_we) begin
            case (csr_index)
               REG_WINDOW_LEFT: regs_copy.window_left = csr_wdata[COORD_BITS-1:0];
               REG_WINDOW_TOP:  regs_copy.window_top  = csr_wdata[COORD_BITS-1:0];
               REG_MATCH_LEFT:  regs_copy.match_left  = csr_wdata[COORD_BITS-1:0];
               REG_MATCH_TOP:   regs_copy.match_top   = csr_wdata[COORD_BITS-1:0];
               REG_WIDTH_A:     regs_copy.width_a     = csr_wdata;
               REG_HEIGHT_A:    regs_copy.height_a    = csr_wdata;
               REG_WIDTH_B:     regs_copy.width_b     = csr_wdata;
               REG_HEIGHT_B:    regs_copy.height_b    = csr_wdata;
               default: ;
            endcase
         end
      end
      pending  <= window_means.size();
      failures <= fail_count;
   end

endmodule

### bench/tb_window_mean_squared_difference.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_window_mean_squared_difference: testbench for the window mean block
// drives pixel windows under many register settings with bursty input and
// random output stalls; the checker beside the block predicts every result
// ----------------------------------------------------------------------------
module tb_window_mean_squared_difference;
   import wmsd_pkg::*;

   localparam int MAX_WINDOW_PIXELS = 4096;
   localparam int RANDOM_ITEMS      = 1150;
   localparam int HOLD_CYCLES       = 400;   // long receiver hold-off
   localparam int SETTLE_CYCLES     = 40;    // margin past the window finish
   localparam int RUN_LIMIT_NS      = 1000000;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_we    = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   int pending;
   int failures;
   int hold_requests = 0;   // bumped by the sender, served by the receiver
   int burst_left    = 0;
   int items_sent    = 0;

   // window origin of the current setting, used to lay out raster windows
   logic [COORD_BITS-1:0] cur_left = '0;
   logic [COORD_BITS-1:0] cur_top  = '0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   window_mean_squared_difference #(
      .MAX_WINDOW_PIXELS(MAX_WINDOW_PIXELS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   wmsd_checker #(
      .MAX_WINDOW_PIXELS(MAX_WINDOW_PIXELS)
   ) mean_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pending   (pending),
      .failures  (failures)
   );

   // pixel level with the extremes weighted up
   function automatic logic [PIX_BITS-1:0] random_level();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return PIX_BITS'($urandom);
   endfunction

   // offer one item; bursts of random length, random gaps between bursts
   task automatic send_pixel(input req_type it);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= it;
      // hold the item until it is taken
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_fields(input logic [COORD_BITS-1:0] col, input logic [COORD_BITS-1:0] row,
                              input logic [PIX_BITS-1:0] pa, input logic [PIX_BITS-1:0] pb,
                              input logic last);
      req_type it;
      it = '{col: col, row: row, pixel_a: pa, pixel_b: pb, last: last};
      send_pixel(it);
   endtask

   // raster window from the current origin; scatter gives noise positions
   // and stray last flags, but the final item always closes the window
   task automatic send_window(input int w, input int h, input bit scatter);
      req_type it;
      for (int y = 0; y < h; y++) begin
         for (int x = 0; x < w; x++) begin
            if (scatter) begin
               it.col  = COORD_BITS'($urandom);
               it.row  = COORD_BITS'($urandom);
               it.last = ($urandom_range(0, 5) == 0);
            end else begin
               it.col  = cur_left + COORD_BITS'(x);
               it.row  = cur_top + COORD_BITS'(y);
               it.last = 1'b0;
            end
            it.pixel_a = random_level();
            it.pixel_b = random_level();
            if (x == w - 1 && y == h - 1) it.last = 1'b1;
            send_pixel(it);
         end
      end
   endtask

   task automatic put_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // writes all eight registers on back-to-back cycles
   task automatic load_registers(input logic [CSR_DATA_BITS-1:0] wl, input logic [CSR_DATA_BITS-1:0] wt,
                                 input logic [CSR_DATA_BITS-1:0] ml, input logic [CSR_DATA_BITS-1:0] mt,
                                 input logic [CSR_DATA_BITS-1:0] wa, input logic [CSR_DATA_BITS-1:0] ha,
                                 input logic [CSR_DATA_BITS-1:0] wb, input logic [CSR_DATA_BITS-1:0] hb);
      put_reg(REG_WINDOW_LEFT, wl);
      put_reg(REG_WINDOW_TOP, wt);
      put_reg(REG_MATCH_LEFT, ml);
      put_reg(REG_MATCH_TOP, mt);
      put_reg(REG_WIDTH_A, wa);
      put_reg(REG_HEIGHT_A, ha);
      put_reg(REG_WIDTH_B, wb);
      put_reg(REG_HEIGHT_B, hb);
      csr_we   <= 1'b0;
      cur_left = wl[COORD_BITS-1:0];
      cur_top  = wt[COORD_BITS-1:0];
   endtask

   // stop offering, let every window result come back, then let the block settle
   task automatic finish_phase();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver: stall modes of random length, plus the long hold-off on request
   initial begin : receiver
      int holds_served, mode, span;
      holds_served = 0;
      mode = 0;
      span = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 80);
         end
         span--;
         case (mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   initial begin : stimulus
      logic [CSR_DATA_BITS-1:0] wl, wt, ml, mt, wa, ha, wb, hb;
      int      phase, phase_base, random_base, pick, target, w, h;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset setting: full-size images, origins at zero
      send_fields(12'd0, 12'd0, 8'hFF, 8'h00, 1'b1);          // largest single difference
      send_fields(12'd4095, 12'd0, 8'd10, 8'd20, 1'b1);       // last column skipped, empty
      send_fields(12'd4094, 12'd4094, 8'h00, 8'hFF, 1'b0);    // corner just inside
      send_fields(12'd0, 12'd4095, 8'd1, 8'd2, 1'b1);         // last row skipped
      send_fields(12'd5, 12'd5, 8'h00, 8'h00, 1'b0);
      send_fields(12'd6, 12'd5, 8'hFF, 8'hFF, 1'b0);
      send_fields(12'd7, 12'd5, 8'd3, 8'd0, 1'b1);
      send_fields(12'd4095, 12'd4095, 8'hFF, 8'hFF, 1'b1);    // both skipped, empty
      finish_phase();

      // window in B lies left of and above A: negative B coordinates pass
      load_registers(13'd100, 13'd200, 13'd0, 13'd0, SIZE_RESET, SIZE_RESET, 13'd10, 13'd10);
      send_fields(12'd50, 12'd205, 8'd200, 8'd100, 1'b0);     // negative B column
      send_fields(12'd50, 12'd150, 8'd17, 8'd0, 1'b0);        // negative B row too
      send_fields(12'd105, 12'd205, 8'h00, 8'hFF, 1'b0);
      send_fields(12'd109, 12'd205, 8'hFF, 8'h00, 1'b0);      // B column on its last column
      send_fields(12'd108, 12'd208, 8'd1, 8'd0, 1'b0);
      send_fields(12'd108, 12'd209, 8'd9, 8'd9, 1'b1);        // B row on its last row
      finish_phase();

      // zero width: every pair is skipped
      load_registers(13'd0, 13'd0, 13'd0, 13'd0, 13'd0, SIZE_RESET, SIZE_RESET, SIZE_RESET);
      send_fields(12'd0, 12'd0, 8'hFF, 8'h00, 1'b0);
      send_fields(12'd1, 12'd1, 8'h00, 8'hFF, 1'b1);
      finish_phase();

      // random settings, each followed by a run of windows
      random_base = items_sent;
      phase = 0;
      while (items_sent - random_base < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            {wl, wt, ml, mt} = '0;
            {wa, ha, wb, hb} = {4{SIZE_RESET}};
         end else if (pick == 1) begin
            // all ones: origins wrap to 4095, sizes at their field maximum
            {wl, wt, ml, mt, wa, ha, wb, hb} = '1;
         end else if (pick == 2) begin
            {wl, wt, ml, mt} = '0;
            wa = CSR_DATA_BITS'($urandom_range(0, 1));
            ha = CSR_DATA_BITS'($urandom_range(0, 1));
            wb = CSR_DATA_BITS'($urandom_range(0, 1));
            hb = CSR_DATA_BITS'($urandom_range(0, 1));
         end else begin
            wl = CSR_DATA_BITS'($urandom);
            wt = CSR_DATA_BITS'($urandom);
            ml = CSR_DATA_BITS'($urandom);
            mt = CSR_DATA_BITS'($urandom);
            if (pick < 7) begin
               // edges land inside the windows that follow
               wa = CSR_DATA_BITS'(wl[COORD_BITS-1:0] + $urandom_range(0, 12));
               ha = CSR_DATA_BITS'(wt[COORD_BITS-1:0] + $urandom_range(0, 8));
               wb = CSR_DATA_BITS'(ml[COORD_BITS-1:0] + $urandom_range(0, 12));
               hb = CSR_DATA_BITS'(mt[COORD_BITS-1:0] + $urandom_range(0, 8));
            end else begin
               wa = CSR_DATA_BITS'($urandom);
               ha = CSR_DATA_BITS'($urandom);
               wb = CSR_DATA_BITS'($urandom);
               hb = CSR_DATA_BITS'($urandom);
            end
         end
         load_registers(wl, wt, ml, mt, wa, ha, wb, hb);

         phase_base = items_sent;
         if (phase == 1 || phase == 7) begin
            // receiver holds off while short windows keep coming: the block backs up
            hold_requests <= hold_requests + 1;
            repeat (16) send_window($urandom_range(1, 3), 1, 1'b0);
         end else begin
            target = $urandom_range(30, 120);
            while (items_sent - phase_base < target) begin
               if ($urandom_range(0, 19) == 0) begin
                  w = $urandom_range(9, 16);
                  h = $urandom_range(6, 12);
               end else begin
                  w = $urandom_range(1, 8);
                  h = $urandom_range(1, 5);
               end
               send_window(w, h, $urandom_range(0, 7) == 0);
            end
         end
         finish_phase();
         phase++;
      end

      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
